### design/rti_pkg.sv
// Shared widths, types and bundles for the ray / triangle intersection pipeline.
package rti_pkg;

  localparam int CW    = 16;          // coordinate width, signed Q8.8
  localparam int EW    = CW + 1;      // edge and origin-offset width
  localparam int XW    = 2 * EW + 1;  // cross product component width
  localparam int MW    = EW + XW;     // dot product term width
  localparam int DW    = MW + 3;      // determinant and numerator width
  localparam int QW    = 31;          // distance width, unsigned Q15.16
  localparam int FRAC  = 16;          // fraction bits of the distance
  localparam int SATSH = QW - FRAC;   // quotient overflow test shift
  localparam int NW    = 36;          // normal component width
  localparam int PW    = CW + QW + 1; // direction times distance width
  localparam int DATW  = 192;         // result tdata width
  localparam int INW   = 6 * CW;      // input tdata width
  localparam int VW    = 3 * CW;      // vertex register width
  localparam int CFGIW = 2;           // configuration index width

  localparam logic [CFGIW-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [CFGIW-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [CFGIW-1:0] REG_VERTEX_C = 2'd2;

  typedef logic [2:0][CW-1:0] vec_t;

  // The origin sits in the low half of the word and the direction above it.
  typedef struct packed {
    vec_t dir;
    vec_t org;
  } ray_t;

  typedef struct packed {
    logic          hit;
    logic          sat;
    logic [DW-1:0] det;
    logic [DW-1:0] nt;
    ray_t          ray;
  } div_in_t;

  typedef struct packed {
    logic          hit;
    logic          sat;
    logic [QW-1:0] quo;
    ray_t          ray;
  } div_out_t;

endpackage

### design/ray_triangle_intersect.sv
// Top level of the Moller-Trumbore ray / triangle intersection pipeline.
//
//  Channel | Direction | Handshake            | Contents
//  in_     | input     | in_tvalid/in_tready   | one ray word
//  out_    | output    | out_tvalid/out_tready | one result word, hit flag in tuser
//  cfg_    | input     | cfg_we                | vertex register writes
//
// A new ray word is taken every cycle while the output is not stalled; each
// word reaches the output register through eight register stages (the first
// captures the word), the 31-stage divider that forms the distance one
// quotient bit per stage, and two register stages after it. Reset is
// synchronous and active low; it clears the vertex registers and every valid
// bit. When the output is stalled the whole pipeline holds, so no word is
// lost or repeated, and in_tready follows the output register.
module ray_triangle_intersect
  import rti_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (16 bits each)
  input  logic [INW-1:0]   in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // distance(31), point_x, point_y, point_z (16 each),
  // normal_x, normal_y, normal_z (36 each), zero padding
  output logic [DATW-1:0]  out_tdata,
  // hit
  output logic             out_tuser,
  input  logic             cfg_we,
  input  logic [CFGIW-1:0] cfg_index,
  input  logic [VW-1:0]    cfg_data
);

  // Vertex registers and the edges derived from them.
  logic [VW-1:0] vtx_a_r, vtx_b_r, vtx_c_r;
  logic signed [EW-1:0] va [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_a_r <= '0;
      vtx_b_r <= '0;
      vtx_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_A: vtx_a_r <= cfg_data;
        REG_VERTEX_B: vtx_b_r <= cfg_data;
        REG_VERTEX_C: vtx_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va[k] = EW'($signed(vtx_a_r[k*CW +: CW]));
      e1[k] = EW'($signed(vtx_b_r[k*CW +: CW])) - va[k];
      e2[k] = EW'($signed(vtx_c_r[k*CW +: CW])) - va[k];
    end
  end

  // The normal depends on the vertices alone, so it is formed beside the
  // pipeline; the registers settle long before any word reaches the output.
  logic signed [2*EW-1:0] na_r [3];
  logic signed [2*EW-1:0] nb_r [3];
  logic signed [NW-1:0]   nrm_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      na_r[k]  <= e1[(k+1)%3] * e2[(k+2)%3];
      nb_r[k]  <= e1[(k+2)%3] * e2[(k+1)%3];
      nrm_r[k] <= NW'(na_r[k]) - NW'(nb_r[k]);
    end
  end

  // The whole pipeline advances whenever the output register can move.
  logic en;
  logic vo_r;
  assign en        = !vo_r || out_tready;
  assign in_tready = en;

  // Stage 1: capture the ray.
  logic v1_r;
  ray_t ray1_r;

  // Stage 2: origin relative to vertex A.
  logic v2_r;
  ray_t ray2_r;
  logic signed [EW-1:0] sv2_r [3];

  // Stage 3: cross product terms for P = D x E2 and Q = S x E1.
  logic v3_r;
  ray_t ray3_r;
  logic signed [EW-1:0]   sv3_r [3];
  logic signed [XW-2:0]   pa3_r [3];
  logic signed [XW-2:0]   pb3_r [3];
  logic signed [XW-2:0]   qa3_r [3];
  logic signed [XW-2:0]   qb3_r [3];

  // Stage 4: P and Q.
  logic v4_r;
  ray_t ray4_r;
  logic signed [EW-1:0] sv4_r [3];
  logic signed [XW-1:0] p4_r [3];
  logic signed [XW-1:0] q4_r [3];

  // Stage 5: dot product terms.
  logic v5_r;
  ray_t ray5_r;
  logic signed [MW-1:0] md5_r [3];
  logic signed [MW-1:0] mu5_r [3];
  logic signed [MW-1:0] mv5_r [3];
  logic signed [MW-1:0] mt5_r [3];

  // Stage 6: determinant and numerators.
  logic v6_r;
  ray_t ray6_r;
  logic signed [DW-1:0] det6_r, nu6_r, nv6_r, nt6_r;

  // Stage 7: sign folded so that the determinant is not negative.
  logic v7_r;
  ray_t ray7_r;
  logic nz7_r;
  logic signed [DW-1:0] det7_r, nu7_r, nv7_r, nt7_r;

  // Stage 8: hit decision and overflow test, feeding the divider.
  logic    v8_r;
  div_in_t d8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  logic signed [DW:0] uv7;
  logic signed [DW:0] det7x;
  assign uv7   = (DW+1)'(nu7_r) + (DW+1)'(nv7_r);
  assign det7x = (DW+1)'(det7_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r <= in_tdata;

      ray2_r <= ray1_r;
      for (int k = 0; k < 3; k++) begin
        sv2_r[k] <= EW'($signed(ray1_r.org[k])) - va[k];
      end

      ray3_r <= ray2_r;
      for (int k = 0; k < 3; k++) begin
        sv3_r[k] <= sv2_r[k];
        pa3_r[k] <= $signed(ray2_r.dir[(k+1)%3]) * e2[(k+2)%3];
        pb3_r[k] <= $signed(ray2_r.dir[(k+2)%3]) * e2[(k+1)%3];
        qa3_r[k] <= sv2_r[(k+1)%3] * e1[(k+2)%3];
        qb3_r[k] <= sv2_r[(k+2)%3] * e1[(k+1)%3];
      end

      ray4_r <= ray3_r;
      for (int k = 0; k < 3; k++) begin
        sv4_r[k] <= sv3_r[k];
        p4_r[k]  <= XW'(pa3_r[k]) - XW'(pb3_r[k]);
        q4_r[k]  <= XW'(qa3_r[k]) - XW'(qb3_r[k]);
      end

      ray5_r <= ray4_r;
      for (int k = 0; k < 3; k++) begin
        md5_r[k] <= e1[k] * p4_r[k];
        mu5_r[k] <= sv4_r[k] * p4_r[k];
        mv5_r[k] <= MW'($signed(ray4_r.dir[k])) * MW'(q4_r[k]);
        mt5_r[k] <= e2[k] * q4_r[k];
      end

      ray6_r <= ray5_r;
      det6_r <= DW'(md5_r[0]) + DW'(md5_r[1]) + DW'(md5_r[2]);
      nu6_r  <= DW'(mu5_r[0]) + DW'(mu5_r[1]) + DW'(mu5_r[2]);
      nv6_r  <= DW'(mv5_r[0]) + DW'(mv5_r[1]) + DW'(mv5_r[2]);
      nt6_r  <= DW'(mt5_r[0]) + DW'(mt5_r[1]) + DW'(mt5_r[2]);

      ray7_r <= ray6_r;
      nz7_r  <= (det6_r != '0);
      if (det6_r[DW-1]) begin
        det7_r <= -det6_r;
        nu7_r  <= -nu6_r;
        nv7_r  <= -nv6_r;
        nt7_r  <= -nt6_r;
      end else begin
        det7_r <= det6_r;
        nu7_r  <= nu6_r;
        nv7_r  <= nv6_r;
        nt7_r  <= nt6_r;
      end

      d8_r.ray <= ray7_r;
      d8_r.det <= det7_r;
      d8_r.nt  <= nt7_r;
      d8_r.hit <= nz7_r && !nu7_r[DW-1] && !(det7_r < nu7_r) && !nv7_r[DW-1]
                  && !(det7x < uv7) && !nt7_r[DW-1] && (nt7_r != '0);
      d8_r.sat <= ((nt7_r >>> SATSH) >= det7_r);
    end
  end

  // Distance quotient.
  logic     dv;
  div_out_t dq;

  rti_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v8_r),
    .din       (d8_r),
    .out_valid (dv),
    .dout      (dq)
  );

  // Stage after the divider: saturate the distance and scale the direction.
  logic                 vm_r;
  logic                 hitm_r;
  logic [QW-1:0]        distm_r;
  vec_t                 orgm_r;
  logic signed [PW-1:0] prm_r [3];
  logic [QW-1:0]        dist_c;

  assign dist_c = dq.sat ? {QW{1'b1}} : dq.quo;

  // Output register.
  logic                 hito_r;
  logic [QW-1:0]        disto_r;
  logic signed [CW-1:0] pto_r [3];
  logic signed [NW-1:0] nrmo_r [3];

  logic signed [PW-FRAC:0] pt_c [3];
  logic signed [CW-1:0]    pts_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt_c[k] = (PW-FRAC+1)'($signed(orgm_r[k])) + (PW-FRAC+1)'(prm_r[k] >>> FRAC);
      if (pt_c[k] > (PW-FRAC+1)'(32767)) begin
        pts_c[k] = CW'(32767);
      end else if (pt_c[k] < -(PW-FRAC+1)'(32768)) begin
        pts_c[k] = CW'(-32768);
      end else begin
        pts_c[k] = pt_c[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vm_r <= dv;
      vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hitm_r  <= dq.hit;
      distm_r <= dist_c;
      orgm_r  <= dq.ray.org;
      for (int k = 0; k < 3; k++) begin
        prm_r[k] <= PW'($signed(dq.ray.dir[k])) * $signed({1'b0, dist_c});
      end

      hito_r  <= hitm_r;
      disto_r <= hitm_r ? distm_r : '0;
      for (int k = 0; k < 3; k++) begin
        pto_r[k]  <= hitm_r ? pts_c[k] : '0;
        nrmo_r[k] <= hitm_r ? nrm_r[k] : '0;
      end
    end
  end

  assign out_tvalid = vo_r;
  assign out_tuser  = hito_r;
  assign out_tdata  = {5'd0, nrmo_r[2], nrmo_r[1], nrmo_r[0],
                       pto_r[2], pto_r[1], pto_r[0], disto_r};

endmodule

### design/rti_div.sv
// Pipelined restoring divider producing one distance bit per stage.
module rti_div
  import rti_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  div_in_t  din,
  output logic     out_valid,
  output div_out_t dout
);

  logic                 v_r    [QW];
  logic [DW-1:0]        rem_r  [QW];
  logic [QW-1:0]        q_r    [QW];
  logic [DW-1:0]        det_r  [QW];
  logic [SATSH-1:0]     ntl_r  [QW];
  logic                 hit_r  [QW];
  logic                 sat_r  [QW];
  ray_t                 ray_r  [QW];

  genvar j;
  generate
    for (j = 0; j < QW; j++) begin : g_stage
      localparam int BI = QW - 1 - j;
      logic             v_p;
      logic [DW-1:0]    rem_p;
      logic [QW-1:0]    q_p;
      logic [DW-1:0]    det_p;
      logic [SATSH-1:0] ntl_p;
      logic             hit_p;
      logic             sat_p;
      ray_t             ray_p;
      logic             nbit;
      logic [DW:0]      trial;
      logic             ge;

      if (j == 0) begin : g_first
        assign v_p   = in_valid;
        assign rem_p = din.nt >> SATSH;
        assign q_p   = '0;
        assign det_p = din.det;
        assign ntl_p = din.nt[SATSH-1:0];
        assign hit_p = din.hit;
        assign sat_p = din.sat;
        assign ray_p = din.ray;
      end else begin : g_next
        assign v_p   = v_r[j-1];
        assign rem_p = rem_r[j-1];
        assign q_p   = q_r[j-1];
        assign det_p = det_r[j-1];
        assign ntl_p = ntl_r[j-1];
        assign hit_p = hit_r[j-1];
        assign sat_p = sat_r[j-1];
        assign ray_p = ray_r[j-1];
      end

      if (BI >= FRAC) begin : g_bit
        assign nbit = ntl_p[BI-FRAC];
      end else begin : g_zero
        assign nbit = 1'b0;
      end

      assign trial = {rem_p, nbit};
      assign ge    = (trial >= {1'b0, det_p});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[j] <= 1'b0;
        end else if (en) begin
          v_r[j] <= v_p;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? DW'(trial - {1'b0, det_p}) : trial[DW-1:0];
          q_r[j]   <= {q_p[QW-2:0], ge};
          det_r[j] <= det_p;
          ntl_r[j] <= ntl_p;
          hit_r[j] <= hit_p;
          sat_r[j] <= sat_p;
          ray_r[j] <= ray_p;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[QW-1];
  assign dout.hit  = hit_r[QW-1];
  assign dout.sat  = sat_r[QW-1];
  assign dout.quo  = q_r[QW-1];
  assign dout.ray  = ray_r[QW-1];

endmodule
